@@ src/frma_pkg.sv @@
// Shared types and constants of the frame-rate moving-average meter.
`default_nettype none

package frma_pkg;

   // Fixed field widths
   localparam int unsigned RATE_W = 20;            // tick rate, per-frame rate, fps
   localparam int unsigned TICK_W = 32;            // free-running tick count
   localparam int unsigned SUM_W  = 26;            // running sum of up to 64 rates
   localparam int unsigned CSR_BYTES_W = 24;       // tick rate padded to whole bytes
   localparam int unsigned RSP_BYTES_W = 24;       // fps padded to whole bytes

   localparam logic [RATE_W-1:0] TICK_RATE_RESET = 20'd1000;

   // Shared divider geometry: dividend is at most SUM_W bits, divisor up to TICK_W bits
   localparam int unsigned DVD_W = SUM_W;
   localparam int unsigned DVS_W = TICK_W;
   localparam int unsigned DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 5'(DVD_W - 1);

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_cmd_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SUB    = 7'b0000010,
      ST_RDIV   = 7'b0000100,
      ST_UPD    = 7'b0001000,
      ST_FSTART = 7'b0010000,
      ST_FDIV   = 7'b0100000,
      ST_OUT    = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

@@ src/frma_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module frma_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire frma_pkg::div_cmd_type     cmd,
   output logic                           done,
   output logic [frma_pkg::DVD_W-1:0]     quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [frma_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [frma_pkg::DVD_W-1:0]        work_ff, work_in;
   logic [frma_pkg::DVS_W-1:0]        rem_ff, rem_in;
   logic [frma_pkg::DVS_W-1:0]        dvs_ff, dvs_in;
   logic [frma_pkg::DVS_W:0]          rem_sh;
   logic [frma_pkg::DVS_W:0]          rem_sub;
   logic                              fits;

   always_comb begin
      rem_sh  = {rem_ff, work_ff[frma_pkg::DVD_W-1]};
      fits    = (rem_sh >= {1'b0, dvs_ff});
      rem_sub = rem_sh - {1'b0, dvs_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = frma_pkg::DIV_LAST_STEP;
         work_in = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in  = fits ? rem_sub[frma_pkg::DVS_W-1:0] : rem_sh[frma_pkg::DVS_W-1:0];
         work_in = {work_ff[frma_pkg::DVD_W-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

`default_nettype wire

@@ src/frame_rate_moving_average.sv @@
// Top level of the moving-average frame-rate meter.
`default_nettype none

// Frame-rate meter: each req beat is one frame event carrying the current 32-bit tick
// count; each produces exactly one rsp beat with the average frames per second over
// the last WINDOW frames (or fewer, until the window has filled). The per-frame rate
// is tick_rate_hz divided by the wrapping tick difference to the last frame whose tick
// changed; a repeated tick counts as rate 0. Both divisions run on one shared restoring
// divider that produces a quotient bit per cycle; an event runs two 26-step divisions
// when the tick changed and one when it did not, and req_tready stays low from its
// acceptance until its result is loaded. A finished result waits in the rsp register,
// and the next event may be accepted meanwhile. The rate history sits in a WINDOW-entry
// memory read and written at the ring index. Write tick_rate_hz only while idle.
module frame_rate_moving_average #(
   parameter int unsigned WINDOW = 50              // 2..64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration write channel
   input  wire logic        csr_tvalid,
   output logic             csr_tready,
   input  wire logic [23:0] csr_tdata,             // [19:0] tick_rate_hz, [23:20] zero
   // frame events
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,             // [31:0] tick_now
   // averaged rate
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata              // [19:0] fps, [23:20] zero
);

   localparam int unsigned IDX_W  = $clog2(WINDOW);
   localparam int unsigned FILL_W = $clog2(WINDOW + 1);
   localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(WINDOW - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);

   frma_pkg::state_type                  state_ff, state_in;
   logic [frma_pkg::RATE_W-1:0]          tick_rate_ff, tick_rate_in;
   logic [frma_pkg::TICK_W-1:0]          last_tick_ff, last_tick_in;
   logic [frma_pkg::TICK_W-1:0]          tick_ff, tick_in;
   logic [frma_pkg::SUM_W-1:0]           sum_ff, sum_in;
   logic [IDX_W-1:0]                     idx_ff, idx_in;
   logic [FILL_W-1:0]                    fill_ff, fill_in;
   logic [frma_pkg::RATE_W-1:0]          rate_ff, rate_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [frma_pkg::RATE_W-1:0]          fps_ff, fps_in;

   logic [frma_pkg::RATE_W-1:0]          ring [WINDOW];
   logic [frma_pkg::RATE_W-1:0]          ring_rd_ff;
   logic                                 ring_we;

   frma_pkg::div_cmd_type                div_cmd;
   logic                                 div_done;
   logic [frma_pkg::DVD_W-1:0]           div_q;

   logic                                 req_take;
   logic                                 csr_take;
   logic                                 rsp_free;

   assign req_tready = (state_ff == frma_pkg::ST_IDLE);
   assign csr_tready = (state_ff == frma_pkg::ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign csr_take   = csr_tvalid && csr_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   frma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in     = state_ff;
      tick_rate_in = tick_rate_ff;
      last_tick_in = last_tick_ff;
      tick_in      = tick_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      rate_in      = rate_ff;
      fps_in       = fps_ff;
      ring_we      = 1'b0;
      div_cmd      = '{start: 1'b0, dividend: '0, divisor: '0};

      // retire the held result once the sink takes it
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (csr_take) begin
         tick_rate_in = csr_tdata[frma_pkg::RATE_W-1:0];
      end

      unique case (state_ff)
         frma_pkg::ST_IDLE: begin
            if (req_take) begin
               tick_in  = req_tdata;
               state_in = frma_pkg::ST_SUB;
            end
         end
         frma_pkg::ST_SUB: begin
            // grow the fill count, or drop the oldest rate once the window is full
            if (fill_ff != FILL_FULL) begin
               fill_in = fill_ff + 1'b1;
            end else begin
               sum_in = sum_ff - {{(frma_pkg::SUM_W - frma_pkg::RATE_W){1'b0}}, ring_rd_ff};
            end
            if (tick_ff != last_tick_ff) begin
               div_cmd.start    = 1'b1;
               div_cmd.dividend = {{(frma_pkg::DVD_W - frma_pkg::RATE_W){1'b0}},
                                   tick_rate_ff};
               div_cmd.divisor  = tick_ff - last_tick_ff;
               last_tick_in     = tick_ff;
               state_in         = frma_pkg::ST_RDIV;
            end else begin
               rate_in  = '0;
               state_in = frma_pkg::ST_UPD;
            end
         end
         frma_pkg::ST_RDIV: begin
            if (div_done) begin
               rate_in  = div_q[frma_pkg::RATE_W-1:0];
               state_in = frma_pkg::ST_UPD;
            end
         end
         frma_pkg::ST_UPD: begin
            // store the new rate, add it, advance the ring
            ring_we  = 1'b1;
            sum_in   = sum_ff + {{(frma_pkg::SUM_W - frma_pkg::RATE_W){1'b0}}, rate_ff};
            idx_in   = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
            state_in = frma_pkg::ST_FSTART;
         end
         frma_pkg::ST_FSTART: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = sum_ff;
            div_cmd.divisor  = {{(frma_pkg::DVS_W - FILL_W){1'b0}}, fill_ff};
            state_in         = frma_pkg::ST_FDIV;
         end
         frma_pkg::ST_FDIV: begin
            if (div_done) begin
               state_in = frma_pkg::ST_OUT;
            end
         end
         frma_pkg::ST_OUT: begin
            // hold the quotient until the output register is free
            if (rsp_free) begin
               fps_in       = div_q[frma_pkg::RATE_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = frma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = frma_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frma_pkg::ST_IDLE;
         tick_rate_ff <= frma_pkg::TICK_RATE_RESET;
         last_tick_ff <= '0;
         sum_ff       <= '0;
         idx_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_rate_ff <= tick_rate_in;
         last_tick_ff <= last_tick_in;
         sum_ff       <= sum_in;
         idx_ff       <= idx_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_ff <= tick_in;
      rate_ff <= rate_in;
      fps_ff  <= fps_in;
   end

   // rate history: a write in ST_UPD and one registered read per cycle, both at the ring index
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring[idx_ff] <= rate_ff;
      end
      ring_rd_ff <= ring[idx_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(frma_pkg::RSP_BYTES_W - frma_pkg::RATE_W){1'b0}}, fps_ff};

endmodule

`default_nettype wire

@@ src/frma_check.sv @@
// Port-level checker for the frame-rate meter, bound to the top level.
`default_nettype none

module frma_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // an accepted event keeps the block busy for the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted back to back");

   // padding bits above fps stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:20] == 4'd0)
      else $error("rsp padding not zero");

   // reset leaves no result pending and the block ready
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("state after reset wrong");

endmodule

bind frame_rate_moving_average frma_check u_frma_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
